@@ rtl/sagq_pkg.sv @@
// Package for the sample average gamma quantizer.
// Holds widths and the payload structs. No dependencies.
package sagq_pkg;

  localparam int unsigned MaxSamples = 1024;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned SumW       = 27;
  localparam int unsigned SppW       = 11;
  localparam int unsigned ByteW      = 8;

  typedef struct packed {
    logic [SumW-1:0] red_sum;
    logic [SumW-1:0] green_sum;
    logic [SumW-1:0] blue_sum;
  } in_word_t;

  typedef struct packed {
    logic [ByteW-1:0] red_byte;
    logic [ByteW-1:0] green_byte;
    logic [ByteW-1:0] blue_byte;
  } out_word_t;

endpackage

@@ rtl/sagq_div_cell.sv @@
// One restoring divide step for the three components.
// Depends on sagq_pkg.
module sagq_div_cell #(
  parameter int unsigned DivW = 11,
  parameter int unsigned Bit  = 0
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic                           en_i,
  input  logic [DivW-1:0]                div_i,
  input  logic [2:0][sagq_pkg::SumW-1:0] rem_i,
  input  logic [2:0][sagq_pkg::SumW-1:0] quo_i,
  output logic                           valid_o,
  output logic [DivW-1:0]                div_o,
  output logic [2:0][sagq_pkg::SumW-1:0] rem_o,
  output logic [2:0][sagq_pkg::SumW-1:0] quo_o
);
  localparam int unsigned W = sagq_pkg::SumW + DivW;

  logic                           valid_q;
  logic [DivW-1:0]                div_q;
  logic [2:0][sagq_pkg::SumW-1:0] rem_d, rem_q, quo_d, quo_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [W-1:0] sh;
      sh = {{DivW{1'b0}}, rem_i[c]} >> Bit;
      rem_d[c] = rem_i[c];
      quo_d[c] = quo_i[c];
      if (sh >= {{sagq_pkg::SumW{1'b0}}, div_i}) begin
        rem_d[c] = rem_i[c] - sagq_pkg::SumW'({{sagq_pkg::SumW{1'b0}}, div_i} << Bit);
        quo_d[c][Bit] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_i;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
endmodule

@@ rtl/sagq_sqrt_cell.sv @@
// One bit-decision step of the 8-bit square root for three components.
// Depends on sagq_pkg.
module sagq_sqrt_cell #(
  parameter int unsigned MeanW = 27,
  parameter int unsigned Bit   = 7
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic                          en_i,
  input  logic [2:0][MeanW-1:0]         val_i,
  input  logic [2:0][sagq_pkg::ByteW-1:0] root_i,
  output logic                          valid_o,
  output logic [2:0][MeanW-1:0]         val_o,
  output logic [2:0][sagq_pkg::ByteW-1:0] root_o
);
  logic                            valid_q;
  logic [2:0][MeanW-1:0]           val_q;
  logic [2:0][sagq_pkg::ByteW-1:0] root_d, root_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [sagq_pkg::ByteW-1:0] cand;
      logic [2*sagq_pkg::ByteW-1:0] sq;
      cand = root_i[c] | sagq_pkg::ByteW'(1 << Bit);
      sq = cand * cand;
      root_d[c] = root_i[c];
      if ({{MeanW{1'b0}}, sq} <= {{2*sagq_pkg::ByteW{1'b0}}, val_i[c]}) root_d[c] = cand;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q  <= val_i;
      root_q <= root_d;
    end
  end

  assign valid_o = valid_q;
  assign val_o   = val_q;
  assign root_o  = root_q;
endmodule

@@ rtl/sample_average_gamma_quantizer.sv @@
// Top level: divide chain followed by square root chain, one pixel per cycle while the output is not stalled.
// Depends on sagq_pkg, sagq_div_cell and sagq_sqrt_cell.
//
// channel  | signals                       | dir
// in       | in_valid_i/in_ready_o/in_data_i  | in
// out      | out_valid_o/out_ready_i/out_data_o | out
// cfg      | cfg_valid_i/cfg_ready_o/cfg_data_i | in
//
// The chain is SumW divide cells plus 8 root cells; one word per cycle while the output is not stalled.
// The chain advances as one whenever the last cell is empty or being taken.
// A stall at the output holds every cell. Reset empties the chain and sets
// the divisor register to 1.
module sample_average_gamma_quantizer #(
  parameter int unsigned MAX_SAMPLES = sagq_pkg::MaxSamples,
  parameter int unsigned FRAC_BITS   = sagq_pkg::FracBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  sagq_pkg::in_word_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output sagq_pkg::out_word_t          out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sagq_pkg::SppW-1:0]    cfg_data_i
);
  localparam int unsigned SW   = sagq_pkg::SumW;
  localparam int unsigned DivW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned MW   = SW + 16;

  logic [sagq_pkg::SppW-1:0] spp_q;
  logic [DivW-1:0]           div_eff;
  logic                      en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spp_q <= sagq_pkg::SppW'(1);
    end else if (cfg_valid_i) begin
      spp_q <= cfg_data_i;
    end
  end
  assign cfg_ready_o = 1'b1;

  always_comb begin
    logic [31:0] s;
    s = 32'(spp_q);
    if (s == 32'd0) s = 32'd1;
    if (s > 32'(MAX_SAMPLES)) s = 32'(MAX_SAMPLES);
    div_eff = DivW'(s);
  end

  logic [SW:0]                   dv;
  logic [SW:0][DivW-1:0]         dd;
  logic [SW:0][2:0][SW-1:0]      dr, dq;

  assign dv[0] = in_valid_i;
  assign dd[0] = div_eff;
  assign dr[0] = {in_data_i.red_sum, in_data_i.green_sum, in_data_i.blue_sum};
  assign dq[0] = '0;

  for (genvar i = 0; i < SW; i++) begin : g_div
    sagq_div_cell #(.DivW(DivW), .Bit(SW-1-i)) u_cell (
      .clk_i, .rst_ni, .valid_i(dv[i]), .en_i(en), .div_i(dd[i]),
      .rem_i(dr[i]), .quo_i(dq[i]), .valid_o(dv[i+1]), .div_o(dd[i+1]),
      .rem_o(dr[i+1]), .quo_o(dq[i+1])
    );
  end

  logic [8:0]                            sv;
  logic [8:0][2:0][MW-1:0]               sval;
  logic [8:0][2:0][sagq_pkg::ByteW-1:0]  sroot;

  assign sv[0] = dv[SW];
  for (genvar c = 0; c < 3; c++) begin : g_scale
    if (FRAC_BITS <= 16) begin : g_up
      assign sval[0][c] = {16'b0, dq[SW][c]} << (16 - FRAC_BITS);
    end else begin : g_dn
      assign sval[0][c] = {16'b0, dq[SW][c]} >> (FRAC_BITS - 16);
    end
  end
  assign sroot[0] = '0;

  for (genvar j = 0; j < 8; j++) begin : g_sqrt
    sagq_sqrt_cell #(.MeanW(MW), .Bit(7-j)) u_cell (
      .clk_i, .rst_ni, .valid_i(sv[j]), .en_i(en), .val_i(sval[j]),
      .root_i(sroot[j]), .valid_o(sv[j+1]), .val_o(sval[j+1]), .root_o(sroot[j+1])
    );
  end

  assign en          = !sv[8] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = sv[8];
  assign out_data_o  = '{red_byte: sroot[8][2], green_byte: sroot[8][1],
                         blue_byte: sroot[8][0]};

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o) else $error("stalled with empty output");
  a_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_eff != '0) else $error("zero divisor");
endmodule

@@ verif/sample_average_gamma_quantizer_tb.sv @@
// Testbench for the sample average gamma quantizer: random and directed pixel sums,
// several divisor settings, stalls on both sides. Depends on sagq_pkg and the RTL top.
module sample_average_gamma_quantizer_tb;

  localparam int unsigned SumW       = sagq_pkg::SumW;
  localparam int unsigned SppW       = sagq_pkg::SppW;
  localparam int unsigned ByteW      = sagq_pkg::ByteW;
  localparam int unsigned MaxSamples = sagq_pkg::MaxSamples;
  localparam int unsigned SumMax     = 67108864;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned Latency    = 35;

  class pixel_scoreboard;
    sagq_pkg::out_word_t pending[$];
    logic [SppW-1:0] divisor = SppW'(1);
    int unsigned n_errors  = 0;
    int unsigned n_checked = 0;

    function logic [ByteW-1:0] root_byte(logic [SumW-1:0] sum);
      logic [SumW-1:0] div;
      logic [SumW-1:0] mean;
      logic [ByteW-1:0] r;
      logic [ByteW-1:0] c;
      div = SumW'((divisor == 0) ? 1 : ((divisor > MaxSamples) ? MaxSamples : divisor));
      mean = sum / div;
      r = '0;
      for (int b = ByteW - 1; b >= 0; b--) begin
        c = r | (8'd1 << b);
        if (40'(c) * 40'(c) <= 40'(mean)) r = c;
      end
      return r;
    endfunction

    function void note_pixel(sagq_pkg::in_word_t w);
      sagq_pkg::out_word_t e;
      e.red_byte   = root_byte(w.red_sum);
      e.green_byte = root_byte(w.green_sum);
      e.blue_byte  = root_byte(w.blue_sum);
      pending.push_back(e);
    endfunction

    function void check_bytes(sagq_pkg::out_word_t got);
      sagq_pkg::out_word_t e;
      n_checked++;
      if (pending.size() == 0) begin
        $error("unexpected output word %h", got);
        n_errors++;
        return;
      end
      e = pending.pop_front();
      if (got.red_byte !== e.red_byte) begin
        $error("red_byte expected %0d actual %0d", e.red_byte, got.red_byte);
        n_errors++;
      end
      if (got.green_byte !== e.green_byte) begin
        $error("green_byte expected %0d actual %0d", e.green_byte, got.green_byte);
        n_errors++;
      end
      if (got.blue_byte !== e.blue_byte) begin
        $error("blue_byte expected %0d actual %0d", e.blue_byte, got.blue_byte);
        n_errors++;
      end
    endfunction
  endclass

  logic                clk_i = 0;
  logic                rst_ni = 0;
  logic                in_valid_i = 0;
  logic                in_ready_o;
  sagq_pkg::in_word_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 0;
  sagq_pkg::out_word_t out_data_o;
  logic                cfg_valid_i = 0;
  logic                cfg_ready_o;
  logic [SppW-1:0]     cfg_data_i = '0;

  pixel_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned n_sent = 0;
  bit          hold_off = 0;
  bit          stall_on = 1;

  sample_average_gamma_quantizer i_dut (.*);

  initial forever #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Note accepted words and check results at the sampling edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_pixel(in_data_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_bytes(out_data_o);
  end

  // Receiver stall pattern: stretches of random or full readiness, each picked at random.
  int unsigned phase_cnt = 0;
  bit          rand_mode = 0;
  always @(posedge clk_i) begin
    if (phase_cnt == 0) begin
      phase_cnt <= $urandom_range(20, 200);
      rand_mode <= 1'($urandom_range(0, 1));
    end else begin
      phase_cnt <= phase_cnt - 1;
    end
    if (hold_off || !stall_on) out_ready_i <= hold_off ? 1'b0 : 1'b1;
    else out_ready_i <= rand_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
  end

  function automatic int unsigned pick_sum();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return SumMax;
      2: return $urandom_range(0, 65535);
      3: return $urandom_range(0, 1 << 20);
      default: return $urandom_range(0, SumMax);
    endcase
  endfunction

  task automatic send_pixel(int unsigned r, int unsigned g, int unsigned b);
    sagq_pkg::in_word_t w;
    w.red_sum = SumW'(r);
    w.green_sum = SumW'(g);
    w.blue_sum = SumW'(b);
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    n_sent++;
  endtask

  task automatic send_burst(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_pixel(pick_sum(), pick_sum(), pick_sum());
    in_valid_i <= 1'b0;
    repeat ($urandom_range(0, 4)) @(posedge clk_i);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
  endtask

  task automatic write_divisor(logic [SppW-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.divisor = v;
  endtask

  task automatic random_phase(int unsigned n);
    int unsigned target;
    target = n_sent + n;
    while (n_sent < target) send_burst($urandom_range(1, 30));
    drain();
  endtask

  logic [SppW-1:0] spp_list[] = '{11'd1, 11'd0, 11'd1024, 11'd2047, 11'd1025, 11'd3, 11'd64};

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    stall_on = 0;

    // Directed: extremes, saturation, root boundaries at reset divisor.
    send_pixel(0, 0, 0);
    send_pixel(SumMax, SumMax, SumMax);
    send_pixel(27'h7FFFFFF, 27'h5555555, 27'h2AAAAAA);
    send_pixel(65024, 65025, 65536);
    send_pixel(1, 3, 4);
    send_pixel(255, 256, 65535);
    in_valid_i <= 1'b0;
    drain();
    write_divisor(11'd1024);
    send_pixel(SumMax, 27'h7FFFFFF, 1023);
    send_pixel(65536 * 1024, 65025 * 1024, 65024 * 1024 + 1023);
    in_valid_i <= 1'b0;
    drain();
    stall_on = 1;

    foreach (spp_list[i]) begin
      write_divisor(spp_list[i]);
      random_phase(120);
    end

    // Hold the receiver off long enough to back the chain up.
    write_divisor(11'd7);
    fork
      send_burst(120);
      begin
        hold_off = 1;
        repeat (150) @(posedge clk_i);
        hold_off = 0;
      end
    join
    drain();

    for (int k = 0; k < 5; k++) begin
      write_divisor(SppW'($urandom_range(0, 2047)));
      random_phase(100);
    end

    $display("Covered %0d pixels, %0d results checked, divisors incl. 0, 1024 and above.",
             n_sent, sb.n_checked);
    if (sb.n_errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

@@ sample_average_gamma_quantizer.f @@
rtl/sagq_pkg.sv
rtl/sagq_div_cell.sv
rtl/sagq_sqrt_cell.sv
rtl/sample_average_gamma_quantizer.sv
verif/sample_average_gamma_quantizer_tb.sv
